>>> hdl/kts_pkg.sv
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types, constants and helpers for the keyframe track sampler.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int unsigned MAX_KEYS = 16;
  localparam int unsigned KEY_AW   = $clog2(MAX_KEYS);
  localparam int unsigned CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int unsigned FRAC_W   = 16;

  // operation codes carried by the kind field
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  // component selects
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  // one stored key
  typedef struct packed {
    logic        [31:0] time_stamp;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } key_row_t;

  // divider request
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  // clamp a 40-bit signed value to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] r;
    if (!v[39] && (|v[38:31])) begin
      r = 32'h7fff_ffff;
    end else if (v[39] && !(&v[38:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // pick one component of a key, sign-extended to 40 bits
  function automatic logic signed [39:0] comp_of(input key_row_t r, input logic [1:0] c);
    logic signed [31:0] v;
    unique case (c)
      COMP_X:  v = r.x;
      COMP_Y:  v = r.y;
      default: v = r.z;
    endcase
    return {{8{v[31]}}, v};
  endfunction

endpackage

>>> hdl/keyframe_track_sampler_core.sv
// ----------------------------------------------------------------------------
// keyframe_track_sampler_core
// Time-sorted keyframe table with clear, add and Catmull-Rom / smoothstep
// sampling, run by a small sequencer over one shared multiplier.
// ----------------------------------------------------------------------------
// One word in gives one word out; the block takes one word at a time. Add
// reads and moves up one row of the key memory each key later than the new
// one, then writes the new key. Sample scans the keys, then runs the 16-step
// restoring divider for the fraction, fetches four keys and runs the shared
// 41x19 multiplier: Horner steps per component for a Catmull-Rom segment, a
// smoothstep and a lerp per component with two keys. The scan alone ends the
// sample when the time falls outside every interval. Results saturate to
// signed Q16.16.
module keyframe_track_sampler_core
  import kts_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [31:0]        time_stamp_i,
  input  logic signed [31:0] value_x_i,
  input  logic signed [31:0] value_y_i,
  input  logic signed [31:0] value_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic               status_o,
  output logic [4:0]         entries_held_o,
  output logic [31:0]        track_duration_o
);

  typedef enum logic [17:0] {
    ST_IDLE    = 18'h00001,
    ST_ADD_RD  = 18'h00002,
    ST_ADD_CK  = 18'h00004,
    ST_ADD_WR  = 18'h00008,
    ST_SRCH_RD = 18'h00010,
    ST_SRCH_CK = 18'h00020,
    ST_DIV     = 18'h00040,
    ST_FETCH   = 18'h00080,
    ST_SQ1     = 18'h00100,
    ST_SQ2     = 18'h00200,
    ST_SQ3     = 18'h00400,
    ST_LMUL    = 18'h00800,
    ST_LACC    = 18'h01000,
    ST_CINIT   = 18'h02000,
    ST_CMUL    = 18'h04000,
    ST_CACC    = 18'h08000,
    ST_CFIN    = 18'h10000,
    ST_DONE    = 18'h20000
  } state_e;

  state_e state_q, state_d;

  // key memory
  key_row_t    key_mem [MAX_KEYS];
  key_row_t    rd_q;
  logic        mem_we;
  logic [KEY_AW-1:0] mem_waddr, mem_raddr;
  key_row_t    mem_wdata;

  // control and working registers
  logic [CNT_W-1:0] total_q, total_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [31:0]      dur_q, dur_d;
  logic [31:0]      t_q, t_d;
  key_row_t         new_q, new_d;
  logic [31:0]      prev_q, prev_d;
  logic [KEY_AW-1:0] idx_q, idx_d;
  logic [FRAC_W-1:0] u_q, u_d;
  logic [2:0]       fcnt_q, fcnt_d;
  key_row_t         p_q [4];
  key_row_t         p_d [4];
  logic [1:0]       comp_q, comp_d;
  logic [1:0]       step_q, step_d;
  logic signed [39:0] h_q, h_d;
  logic signed [59:0] prod_q, prod_d;
  logic             mul_en;
  logic signed [40:0] mul_a;
  logic signed [18:0] mul_b;
  logic [16:0]      s_q, s_d;
  logic [31:0]      res_q [3];
  logic [31:0]      res_d [3];
  logic             status_q, status_d;

  // output register
  logic             ov_q, ov_d;
  logic [31:0]      ox_q, oy_q, oz_q;
  logic             ost_q;
  logic [CNT_W-1:0] ocnt_q;
  logic [31:0]      odur_q;
  logic             out_load;

  // divider
  div_req_t          div_req;
  logic              div_done;
  logic [FRAC_W-1:0] div_quot;

  // segment neighbor indices
  logic [KEY_AW-1:0] pa_idx, pb_idx, f_addr;
  logic [CNT_W-1:0]  idx_ext;

  // Catmull-Rom coefficients for the current component
  logic signed [39:0] e0, e1, e2, e3, c3, c2, c1, c0, coef;
  logic [17:0]        w18;

  kts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // key memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= key_mem[mem_raddr];
  end

  // neighbor indices, ends duplicated
  always_comb begin
    idx_ext = {{(CNT_W-KEY_AW){1'b0}}, idx_q};
    pa_idx  = (idx_q == '0) ? idx_q : idx_q - KEY_AW'(1);
    pb_idx  = ((idx_ext + CNT_W'(2)) >= total_q) ? idx_q + KEY_AW'(1)
                                                  : idx_q + KEY_AW'(2);
    unique case (fcnt_q[1:0])
      2'd0:    f_addr = pa_idx;
      2'd1:    f_addr = idx_q;
      2'd2:    f_addr = idx_q + KEY_AW'(1);
      default: f_addr = pb_idx;
    endcase
  end

  // coefficients
  always_comb begin
    e0 = comp_of(p_q[0], comp_q);
    e1 = comp_of(p_q[1], comp_q);
    e2 = comp_of(p_q[2], comp_q);
    e3 = comp_of(p_q[3], comp_q);
    c3 = e3 - e0 + (e1 + e1 + e1) - (e2 + e2 + e2);
    c2 = (e0 + e0) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
    c1 = e2 - e0;
    c0 = e1 + e1;
    unique case (step_q)
      2'd0:    coef = c2;
      2'd1:    coef = c1;
      default: coef = c0;
    endcase
    w18 = 18'd196608 - {1'b0, u_q, 1'b0};
  end

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      ST_SQ1: begin
        mul_en = 1'b1;
        mul_a  = {25'd0, u_q};
        mul_b  = {3'd0, u_q};
      end
      ST_SQ2: begin
        mul_en = 1'b1;
        mul_a  = {9'd0, prod_q[31:0]};
        mul_b  = {1'b0, w18};
      end
      ST_LMUL: begin
        mul_en = 1'b1;
        mul_a  = 41'(e2 - e1);
        mul_b  = {2'd0, s_q};
      end
      ST_CMUL: begin
        mul_en = 1'b1;
        mul_a  = {h_q[39], h_q};
        mul_b  = {3'd0, u_q};
      end
      default: ;
    endcase
    prod_d = mul_en ? (mul_a * mul_b) : prod_q;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    j_d       = j_q;
    dur_d     = dur_q;
    t_d       = t_q;
    new_d     = new_q;
    prev_d    = prev_q;
    idx_d     = idx_q;
    u_d       = u_q;
    fcnt_d    = fcnt_q;
    p_d       = p_q;
    comp_d    = comp_q;
    step_d    = step_q;
    h_d       = h_q;
    s_d       = s_q;
    res_d     = res_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = j_q[KEY_AW-1:0];
    mem_wdata = rd_q;
    mem_raddr = j_q[KEY_AW-1:0];
    div_req   = '0;
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          t_d      = time_stamp_i;
          new_d    = '{time_stamp: time_stamp_i, x: value_x_i, y: value_y_i,
                       z: value_z_i};
          res_d    = '{default: 32'd0};
          status_d = 1'b0;
          j_d      = '0;
          state_d  = ST_DONE;
          priority case (kind_i)
            KIND_CLEAR: begin
              total_d = '0;
              dur_d   = '0;
            end
            KIND_ADD: begin
              if (total_q == CNT_W'(MAX_KEYS)) begin
                status_d = 1'b1;
              end else begin
                j_d     = total_q;
                state_d = ST_ADD_RD;
              end
            end
            KIND_SAMPLE: begin
              if (total_q != '0) begin
                state_d = ST_SRCH_RD;
              end
            end
            default: ;
          endcase
        end
      end

      // walk down from the top, moving later keys up one row
      ST_ADD_RD: begin
        mem_raddr = KEY_AW'(j_q - CNT_W'(1));
        state_d   = (j_q == '0) ? ST_ADD_WR : ST_ADD_CK;
      end
      ST_ADD_CK: begin
        if (rd_q.time_stamp > t_q) begin
          mem_we  = 1'b1;
          j_d     = j_q - CNT_W'(1);
          state_d = ST_ADD_RD;
        end else begin
          state_d = ST_ADD_WR;
        end
      end
      ST_ADD_WR: begin
        mem_we    = 1'b1;
        mem_wdata = new_q;
        total_d   = total_q + CNT_W'(1);
        if (j_q == total_q) begin
          dur_d = t_q;
        end
        state_d = ST_DONE;
      end

      // interval scan
      ST_SRCH_RD: begin
        state_d = ST_SRCH_CK;
      end
      ST_SRCH_CK: begin
        if ((j_q != '0) && (prev_q <= t_q) && (t_q < rd_q.time_stamp)) begin
          div_req.start = 1'b1;
          div_req.num   = t_q - prev_q;
          div_req.den   = rd_q.time_stamp - prev_q;
          idx_d         = KEY_AW'(j_q - CNT_W'(1));
          state_d       = ST_DIV;
        end else begin
          prev_d = rd_q.time_stamp;
          if ((j_q + CNT_W'(1)) == total_q) begin
            // no interval holds the time: give the last key
            res_d[0] = rd_q.x;
            res_d[1] = rd_q.y;
            res_d[2] = rd_q.z;
            state_d  = ST_DONE;
          end else begin
            j_d     = j_q + CNT_W'(1);
            state_d = ST_SRCH_RD;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          u_d     = div_quot;
          fcnt_d  = '0;
          state_d = ST_FETCH;
        end
      end

      // fetch the four control points
      ST_FETCH: begin
        mem_raddr = f_addr;
        if (fcnt_q != '0) begin
          p_d[2'(fcnt_q - 3'd1)] = rd_q;
        end
        fcnt_d = fcnt_q + 3'd1;
        comp_d = COMP_X;
        if (fcnt_q == 3'd4) begin
          state_d = (total_q == CNT_W'(2)) ? ST_SQ1 : ST_CINIT;
        end
      end

      // smoothstep, then lerp per component
      ST_SQ1: state_d = ST_SQ2;
      ST_SQ2: state_d = ST_SQ3;
      ST_SQ3: begin
        s_d     = prod_q[48:32];
        state_d = ST_LMUL;
      end
      ST_LMUL: state_d = ST_LACC;
      ST_LACC: begin
        res_d[comp_q] = sat32(e1 + $signed(prod_q[55:16]));
        if (comp_q == COMP_Z) begin
          state_d = ST_DONE;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_LMUL;
        end
      end

      // Catmull-Rom Horner steps per component
      ST_CINIT: begin
        h_d     = c3;
        step_d  = '0;
        state_d = ST_CMUL;
      end
      ST_CMUL: state_d = ST_CACC;
      ST_CACC: begin
        h_d = $signed(prod_q[55:16]) + coef;
        if (step_q == 2'd2) begin
          state_d = ST_CFIN;
        end else begin
          step_d  = step_q + 2'd1;
          state_d = ST_CMUL;
        end
      end
      ST_CFIN: begin
        res_d[comp_q] = sat32(h_q >>> 1);
        if (comp_q == COMP_Z) begin
          state_d = ST_DONE;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_CINIT;
        end
      end

      // hand the word to the output register
      ST_DONE: begin
        if (!ov_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output valid
  always_comb begin
    ov_d = ov_q;
    if (out_load) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      dur_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      dur_q   <= dur_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q      <= j_d;
    t_q      <= t_d;
    new_q    <= new_d;
    prev_q   <= prev_d;
    idx_q    <= idx_d;
    u_q      <= u_d;
    fcnt_q   <= fcnt_d;
    p_q      <= p_d;
    comp_q   <= comp_d;
    step_q   <= step_d;
    h_q      <= h_d;
    prod_q   <= prod_d;
    s_q      <= s_d;
    res_q    <= res_d;
    status_q <= status_d;
    if (out_load) begin
      ox_q   <= res_q[0];
      oy_q   <= res_q[1];
      oz_q   <= res_q[2];
      ost_q  <= status_q;
      ocnt_q <= total_q;
      odur_q <= dur_q;
    end
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = ov_q;
  assign out_x_o          = ox_q;
  assign out_y_o          = oy_q;
  assign out_z_o          = oz_q;
  assign status_o         = ost_q;
  assign entries_held_o   = 5'(ocnt_q);
  assign track_duration_o = odur_q;

  // checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(MAX_KEYS))
    else $error("key count beyond table size");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide step");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> entries_held_o == 5'(MAX_KEYS))
    else $error("add rejected with room left");

endmodule

>>> hdl/kts_div.sv
// ----------------------------------------------------------------------------
// kts_div
// Restoring divider: quotient = floor(num * 2^16 / den), num < den.
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module kts_div
  import kts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  output logic              done_o,
  output logic [FRAC_W-1:0] quot_o
);

  localparam int unsigned CW = $clog2(FRAC_W + 1);

  logic [32:0]       rem_q, rem_d;
  logic [31:0]       den_q, den_d;
  logic [FRAC_W-1:0] quo_q, quo_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [32:0]       shifted;

  // one shift-subtract step per cycle
  always_comb begin
    shifted = {rem_q[31:0], 1'b0};
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      rem_d  = {1'b0, req_i.num};
      den_d  = req_i.den;
      cnt_d  = CW'(FRAC_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        quo_d = {quo_q[FRAC_W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[FRAC_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> bench/tb_keyframe_track_sampler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_track_sampler_core
// Self-checking bench for the keyframe track sampler. Directed words cover
// the empty, single-key, two-key and full-table cases, equal key times, and
// sample times before, between and at the keys. Random tracks are then built and
// sampled with random gaps on both handshakes. Each result word is compared
// against a fixed-point track model kept in the scoreboard.
// ----------------------------------------------------------------------------
module tb_keyframe_track_sampler_core;
  import kts_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned ITEM_GOAL = 1300;
  localparam int unsigned DRAIN_CYCLES = 120;

  // one expected result word
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               status;
    logic [4:0]         held;
    logic [31:0]        duration;
  } track_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the key table and predicts each word
  // --------------------------------------------------------------------------
  class track_scoreboard;
    logic [31:0]        key_time[MAX_KEYS];
    logic signed [31:0] key_val[MAX_KEYS][3];
    int unsigned        key_count;
    track_result_t      pending_q[$];
    int unsigned        mismatches;
    int unsigned        words_checked;
    int unsigned        samples_seen;
    int unsigned        full_rejects;

    function new();
      key_count = 0;
      mismatches = 0;
      words_checked = 0;
      samples_seen = 0;
      full_rejects = 0;
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endfunction

    function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    // uniform Catmull-Rom in Horner form, each step floored
    function automatic longint spline(longint p0, longint p1, longint p2, longint p3,
                                      longint u);
      longint c3, c2, c1, h;
      c3 = -p0 + 3 * p1 - 3 * p2 + p3;
      c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c1 = p2 - p0;
      h = c3;
      h = ((h * u) >>> 16) + c2;
      h = ((h * u) >>> 16) + c1;
      h = ((h * u) >>> 16) + 2 * p1;
      return h >>> 1;
    endfunction

    function automatic void sample_at(logic [31:0] t, ref longint r[3]);
      longint unsigned u, s, span;
      int pa, pb;
      for (int c = 0; c < 3; c++) r[c] = 0;
      if (key_count == 0) return;
      for (int i = 0; i + 1 < key_count; i++) begin
        if (t >= key_time[i] && t < key_time[i+1]) begin
          span = 64'(key_time[i+1] - key_time[i]);
          u = (64'(t - key_time[i]) << 16) / span;
          pa = (i == 0) ? i : i - 1;
          pb = (i + 2 >= key_count) ? i + 1 : i + 2;
          for (int c = 0; c < 3; c++) begin
            if (key_count == 2) begin
              s = (u * u * (64'd196608 - 2 * u)) >> 32;
              r[c] = longint'(key_val[i][c]) +
                     (((longint'(key_val[i+1][c]) - longint'(key_val[i][c])) *
                       longint'(s)) >>> 16);
            end else begin
              r[c] = spline(key_val[pa][c], key_val[i][c], key_val[i+1][c],
                            key_val[pb][c], longint'(u));
            end
          end
          return;
        end
      end
      for (int c = 0; c < 3; c++) r[c] = key_val[key_count-1][c];
    endfunction

    // called once per accepted input word
    function automatic void note_input(logic [1:0] kind, logic [31:0] t,
                                       logic signed [31:0] vx, logic signed [31:0] vy,
                                       logic signed [31:0] vz);
      track_result_t e;
      longint r[3];
      int pos;
      for (int c = 0; c < 3; c++) r[c] = 0;
      e.status = 1'b0;
      case (kind)
        KIND_CLEAR: key_count = 0;
        KIND_ADD: begin
          if (key_count >= MAX_KEYS) begin
            e.status = 1'b1;
            full_rejects++;
          end else begin
            pos = 0;
            while (pos < key_count && key_time[pos] <= t) pos++;
            for (int j = key_count; j > pos; j--) begin
              key_time[j] = key_time[j-1];
              key_val[j] = key_val[j-1];
            end
            key_time[pos] = t;
            key_val[pos][0] = vx;
            key_val[pos][1] = vy;
            key_val[pos][2] = vz;
            key_count++;
          end
        end
        KIND_SAMPLE: begin
          sample_at(t, r);
          samples_seen++;
        end
        default: ;
      endcase
      e.x = clamp32(r[0]);
      e.y = clamp32(r[1]);
      e.z = clamp32(r[2]);
      e.held = 5'(key_count);
      e.duration = (key_count == 0) ? 32'd0 : key_time[key_count-1];
      pending_q.push_back(e);
    endfunction

    // called once per accepted result word
    function automatic void check_result(track_result_t got);
      track_result_t e;
      if (pending_q.size() == 0) begin
        report("unexpected word", got.x, 32'd0);
        return;
      end
      e = pending_q.pop_front();
      words_checked++;
      if (got.x !== e.x) report("out_x", got.x, e.x);
      if (got.y !== e.y) report("out_y", got.y, e.y);
      if (got.z !== e.z) report("out_z", got.z, e.z);
      if (got.status !== e.status) report("status", 32'(got.status), 32'(e.status));
      if (got.held !== e.held) report("entries_held", 32'(got.held), 32'(e.held));
      if (got.duration !== e.duration)
        report("track_duration", got.duration, e.duration);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         kind_i = KIND_CLEAR;
  logic [31:0]        time_stamp_i = '0;
  logic signed [31:0] value_x_i = '0;
  logic signed [31:0] value_y_i = '0;
  logic signed [31:0] value_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;
  logic               status_o;
  logic [4:0]         entries_held_o;
  logic [31:0]        track_duration_o;

  track_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  bit          sink_steady = 1'b0;

  keyframe_track_sampler_core i_dut (.*);

  always #5 clk_i = ~clk_i;

  // gap length: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  // random key value, biased toward the extremes now and then
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  // timeout watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // result side: random back-pressure, check at the rising edge
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0) sink_steady = ~sink_steady;
      if (sink_steady) begin
        out_ready_i = 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_ready_i = 1'b0;
      end else begin
        hold = gap_len();
        out_ready_i = (hold == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{out_x_o, out_y_o, out_z_o, status_o, entries_held_o,
                        track_duration_o});
  end

  // drive one word and wait until it is taken
  task automatic send_word(logic [1:0] kind, logic [31:0] t,
                           logic [31:0] vx = 32'd0, logic [31:0] vy = 32'd0,
                           logic [31:0] vz = 32'd0);
    int unsigned gap;
    gap = sink_steady ? 0 : gap_len();
    repeat (gap) @(negedge clk_i);
    in_valid_i = 1'b1;
    kind_i = kind;
    time_stamp_i = t;
    value_x_i = vx;
    value_y_i = vy;
    value_z_i = vz;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(kind, t, vx, vy, vz);
    words_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic add_key(logic [31:0] t);
    send_word(KIND_ADD, t, pick_value(), pick_value(), pick_value());
  endtask

  // one random track: clear, build, then sample around the keys
  task automatic random_track();
    int unsigned n_keys, n_samples, step_max;
    logic [31:0] base, t;
    logic [31:0] times[$];
    case ($urandom_range(0, 9))
      0: n_keys = $urandom_range(0, 1);
      1: n_keys = $urandom_range(14, 19);
      2: n_keys = 2;
      default: n_keys = $urandom_range(3, 8);
    endcase
    step_max = ($urandom_range(0, 3) == 0) ? 32'h0fff_ffff : $urandom_range(1, 1 << 18);
    base = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
    send_word(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
    for (int k = 0; k < n_keys; k++) begin
      if (k > 0 && $urandom_range(0, 9) == 0) t = times[$urandom_range(0, times.size() - 1)];
      else t = base + $urandom_range(0, step_max) * ($urandom_range(0, 9) + 1);
      times.push_back(t);
      add_key(t);
    end
    n_samples = $urandom_range(3, 10);
    for (int k = 0; k < n_samples; k++) begin
      if (times.size() == 0 || $urandom_range(0, 9) == 0) t = $urandom;
      else begin
        t = times[$urandom_range(0, times.size() - 1)];
        case ($urandom_range(0, 3))
          0: ;
          1: t = t - $urandom_range(0, step_max);
          default: t = t + $urandom_range(0, step_max * 4);
        endcase
      end
      if ($urandom_range(0, 29) == 0) send_word(KIND_UNUSED, t, $urandom, $urandom, $urandom);
      else send_word(KIND_SAMPLE, t, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty, single key, two keys, equal times, full table, extremes
    send_word(KIND_SAMPLE, 32'h0001_0000);
    send_word(KIND_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_word(KIND_ADD, 32'h0002_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    send_word(KIND_SAMPLE, 32'h0000_0000);
    send_word(KIND_ADD, 32'h0004_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000);
    send_word(KIND_SAMPLE, 32'h0003_0000);
    send_word(KIND_SAMPLE, 32'h0003_ffff);
    send_word(KIND_SAMPLE, 32'h0004_0000);
    send_word(KIND_ADD, 32'h0002_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_word(KIND_ADD, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_word(KIND_SAMPLE, 32'h0002_0000);
    send_word(KIND_SAMPLE, 32'h0002_8000);
    send_word(KIND_SAMPLE, 32'hffff_fffe);
    send_word(KIND_SAMPLE, 32'hffff_ffff);
    send_word(KIND_SAMPLE, 32'h0001_ffff);
    for (int k = 0; k < 13; k++) add_key(32'h0000_8000 * k);
    send_word(KIND_ADD, 32'h0000_0000, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678);
    send_word(KIND_SAMPLE, 32'h0000_0000);
    send_word(KIND_CLEAR, 32'h0);
    send_word(KIND_SAMPLE, 32'h0002_0000);

    while (words_sent < ITEM_GOAL) random_track();

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d words: %0d samples, %0d full-table rejects, %0d results checked",
             words_sent, sb.samples_seen, sb.full_rejects, sb.words_checked);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> keyframe_track_sampler_core.f
hdl/kts_pkg.sv
hdl/kts_div.sv
hdl/keyframe_track_sampler_core.sv
bench/tb_keyframe_track_sampler_core.sv
